// ----- design/longest_increasing_subsequence_length_defines.svh -----
// Assertion macros shared by the design files of the LIS length block.
// No dependencies; each macro expects clk and rst_n in the scope of its use.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LIS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lis_pkg.sv -----
// Package for the LIS length block: field widths and parameter defaults.
// No dependencies.
package lis_pkg;

  localparam int VALUE_W       = 32;    // width of the input value field
  localparam int LEN_OUT_W     = 11;    // width of the lis_length result field
  localparam int MAX_LEN_DEF   = 1024;  // default tail table depth
  localparam int VALUE_BITS_DEF = 32;   // default significant bits of a value

endpackage

// ----- design/lis_in_if.sv -----
// Input channel of the LIS length block: valid/ready plus value and first.
// Depends on lis_pkg.
interface lis_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lis_pkg::VALUE_W-1:0]   value;
  logic                                 first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

// ----- design/lis_out_if.sv -----
// Result channel of the LIS length block: valid/ready plus length and full flag.
// Depends on lis_pkg.
interface lis_out_if;
  logic                             valid;
  logic                             ready;
  logic [lis_pkg::LEN_OUT_W-1:0]    lis_length;
  logic                             full_res;

  modport source (output valid, output lis_length, output full_res, input ready);
  modport sink   (input valid, input lis_length, input full_res, output ready);
endinterface

// ----- design/longest_increasing_subsequence_length.sv -----
// Longest strictly increasing subsequence length, one binary search per value.
// Depends on lis_pkg, lis_in_if, lis_out_if and the defines header.
//
//   channel  | direction | payload              | transfer when
//   in_ch    | in        | value, first         | valid && ready
//   out_ch   | out       | lis_length, full_res | valid && ready
//
// An item is taken in, searched with P probes and written in an update step,
// where P is at most clog2(length + 1). The probe rate is set by the single
// registered read port of the tail memory, one probe per cycle. Reset clears the
// length and the result valid flag; the tail memory and result payload are not
// cleared. The update waits while an earlier result is not yet taken; a new item
// is taken while a finished result still waits.
`include "longest_increasing_subsequence_length_defines.svh"

module longest_increasing_subsequence_length #(
  parameter int MAX_LEN    = lis_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lis_in_if.sink    in_ch,
  lis_out_if.source out_ch
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_WRITE} state_t;

  state_t                            state_r;
  logic signed [VALUE_BITS-1:0]      key_in;
  logic signed [VALUE_BITS-1:0]      key_r;
  logic [LEN_W-1:0]                  len_r;
  logic [LEN_W-1:0]                  len_eff;
  logic [LEN_W-1:0]                  lo_r, hi_r, mid_r;
  logic [LEN_W-1:0]                  lo_nxt, hi_nxt, mid_nxt;
  logic [LEN_W-1:0]                  len_nxt;
  logic                              less;
  logic                              slot_free;
  logic                              at_end;
  logic                              do_append;
  logic                              is_full;
  logic                              wr_en;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [lis_pkg::LEN_OUT_W-1:0]     out_len_r;
  logic                              out_full_r;

  // Tail memory: one write and one registered read per cycle.
  logic signed [VALUE_BITS-1:0]      tail_mem [MAX_LEN];
  logic signed [VALUE_BITS-1:0]      rd_data_r;
  logic [IDX_W-1:0]                  rd_addr;

  // Keep the low VALUE_BITS bits, or sign-extend when the value is narrower.
  if (VALUE_BITS <= lis_pkg::VALUE_W) begin : g_key_trunc
    assign key_in = in_ch.value[VALUE_BITS-1:0];
  end else begin : g_key_ext
    assign key_in = {{(VALUE_BITS - lis_pkg::VALUE_W){in_ch.value[lis_pkg::VALUE_W-1]}},
                     in_ch.value};
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.lis_length = out_len_r;
  assign out_ch.full_res   = out_full_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign less      = rd_data_r < key_r;
  assign len_eff   = in_ch.first ? '0 : len_r;

  // A new result loads the register; otherwise a taken result empties it.
  assign out_valid_nxt = (state_r == ST_WRITE && slot_free) ? 1'b1
                                                            : (out_valid_r && !out_ch.ready);

  // Search step: open [lo, hi) on a new item or narrow it, and pick the next probe, whose read is registered.
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    unique case (state_r)
      ST_IDLE: begin
        lo_nxt = '0;
        hi_nxt = len_eff;
      end
      ST_SEARCH: begin
        if (less) begin
          lo_nxt = mid_r + LEN_ONE;
        end else begin
          hi_nxt = mid_r;
        end
      end
      ST_WRITE: begin
      end
      default: begin
      end
    endcase
    mid_nxt = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
    rd_addr = mid_nxt[IDX_W-1:0];
    at_end  = !(lo_nxt < hi_nxt);
  end

  // Update: replace a tail, append, or drop the append when the table is full.
  assign do_append = (lo_r >= len_r) && (len_r < LEN_MAX);
  assign is_full   = (lo_r >= len_r) && (len_r == LEN_MAX);
  assign wr_en     = (state_r == ST_WRITE) && slot_free && !is_full;
  assign len_nxt   = do_append ? len_r + LEN_ONE : len_r;

  always_ff @(posedge clk) begin
    rd_data_r <= tail_mem[rd_addr];
    if (wr_en) begin
      tail_mem[lo_r[IDX_W-1:0]] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            key_r <= key_in;
            len_r <= len_eff;
            lo_r  <= lo_nxt;
            hi_r  <= hi_nxt;
            mid_r <= mid_nxt;
            state_r <= at_end ? ST_WRITE : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          lo_r  <= lo_nxt;
          hi_r  <= hi_nxt;
          mid_r <= mid_nxt;
          if (at_end) begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (slot_free) begin
            len_r       <= len_nxt;
            out_len_r   <= lis_pkg::LEN_OUT_W'(len_nxt);
            out_full_r  <= is_full;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `LIS_ASSERT_IMPL(a_len_bound, 1'b1, len_r <= LEN_MAX, "length exceeds table depth")
  `LIS_ASSERT_IMPL(a_search_window, state_r == ST_SEARCH,
                   lo_r <= mid_r && mid_r < hi_r && hi_r <= len_r, "probe outside window")
  `LIS_ASSERT_IMPL(a_full_at_max, wr_en || (state_r == ST_WRITE && slot_free && is_full),
                   !(is_full && len_r != LEN_MAX), "full flag below table depth")
  `LIS_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, state_r != ST_IDLE,
                   "accepted item did not start a search")

endmodule

// ----- verif/longest_increasing_subsequence_length_tb.sv -----
// Self-checking testbench for the LIS length block: directed table, then random sequences.
// Uses lis_pkg, lis_in_if, lis_out_if and longest_increasing_subsequence_length.
// Predicts results with a local patience-sort model, except typed rows; checks in order.
module longest_increasing_subsequence_length_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAIL_DEPTH    = lis_pkg::MAX_LEN_DEF;
  localparam int SHORT_ITEMS   = 170;
  localparam int EXTRA_ITEMS   = 24;
  localparam int HOLD_AT       = 40;    // result count at which the long sink stall starts
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int IDLE_LIMIT    = 3000;

  typedef struct packed {
    logic signed [lis_pkg::VALUE_W-1:0] value;
    logic                               first;
    logic                               typed;     // expectation below is given literally
    logic [lis_pkg::LEN_OUT_W-1:0]      len;
    logic                               full;
  } dir_row_t;

  typedef struct packed {
    logic [lis_pkg::LEN_OUT_W-1:0] len;
    logic                          full;
  } lis_result_t;

  localparam int NUM_ROWS = 23;
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{32'sh0000_0000, 1'b0, 1'b1, 11'd1, 1'b0},
    '{32'sh8000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
    '{32'sh7FFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},
    '{32'sh7FFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},
    '{32'sh8000_0000, 1'b0, 1'b1, 11'd2, 1'b0},
    '{32'shFFFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},
    '{32'sh0000_0000, 1'b0, 1'b1, 11'd3, 1'b0},
    '{32'sh0000_0000, 1'b0, 1'b1, 11'd3, 1'b0},
    '{32'sh0000_0005, 1'b1, 1'b1, 11'd1, 1'b0},
    '{32'sh0000_0004, 1'b0, 1'b1, 11'd1, 1'b0},
    '{32'sh0000_0003, 1'b0, 1'b1, 11'd1, 1'b0},
    '{32'shFFFF_FFFD, 1'b0, 1'b1, 11'd1, 1'b0},
    '{32'sh0000_000A, 1'b0, 1'b1, 11'd2, 1'b0},
    '{32'sh0000_0007, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sh0000_0008, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sh0000_0009, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'shFFFF_FFFB, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sh0000_0001, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sh8000_0001, 1'b1, 1'b1, 11'd1, 1'b0},
    '{32'sh7FFF_FFFE, 1'b1, 1'b1, 11'd1, 1'b0},
    '{32'sh5555_5555, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'shAAAA_AAAA, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sh7FFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  lis_in_if  in_ch ();
  lis_out_if out_ch ();

  longest_increasing_subsequence_length DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local model state: smallest tail per subsequence length and the current length.
  logic signed [lis_pkg::VALUE_W-1:0] tails [TAIL_DEPTH];
  int                                 run_len;

  lis_result_t pending_results [$];
  int          mismatches;
  int          items_sent;
  int          results_checked;
  int          full_drops;
  int          longest_seen;
  int          idle_cycles;

  logic send_burst = 1'b0;
  logic sink_burst = 1'b0;

  function automatic lis_result_t lis_predict(logic signed [lis_pkg::VALUE_W-1:0] v, logic f);
    int          lo;
    int          hi;
    int          mid;
    lis_result_t res;
    lo = 0;
    if (f) run_len = 0;
    hi = run_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tails[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    res.full = 1'b0;
    if (lo < run_len) begin
      tails[lo] = v;
    end else if (run_len < TAIL_DEPTH) begin
      tails[run_len] = v;
      run_len++;
    end else begin
      res.full = 1'b1;
    end
    res.len = lis_pkg::LEN_OUT_W'(run_len);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one item after a random gap and waits for its transfer.
  task automatic send_value(logic signed [lis_pkg::VALUE_W-1:0] v, logic f,
                            logic typed = 1'b0, lis_result_t literal = '0);
    int          gap;
    lis_result_t res;
    if (items_sent % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.first <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = lis_predict(v, f);
    pending_results.push_back(typed ? literal : res);
    items_sent++;
  endtask

  initial begin : stimulus
    logic signed [lis_pkg::VALUE_W-1:0] v;
    int                                 seq_len;
    int                                 mode;
    int                                 short_sent;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.first <= 1'b0;
    rst_n       <= 1'b0;
    mismatches      = 0;
    items_sent      = 0;
    results_checked = 0;
    full_drops      = 0;
    longest_seen    = 0;
    run_len         = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i])
      send_value(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].typed,
                 '{len: DIRECTED_ROWS[i].len, full: DIRECTED_ROWS[i].full});

    // Short sequences with assorted value shapes; most start with a first flag.
    short_sent = 0;
    while (short_sent < SHORT_ITEMS) begin
      seq_len = $urandom_range(1, 40);
      mode    = $urandom_range(0, 3);
      v       = $urandom;
      for (int k = 0; k < seq_len; k++) begin
        case (mode)
          0: v = $urandom;
          1: v = $signed($urandom_range(0, 15)) - 8;
          2: v = v + $signed($urandom_range(0, 60)) - 12;
          default: v = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                                  : 32'sh8000_0000 + $urandom_range(0, 3);
        endcase
        send_value(v, (k == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 30) == 0));
        short_sent++;
      end
    end

    // One strictly increasing run that fills the tail table completely.
    v = 32'sh8000_0000 + $urandom_range(0, 1000);
    for (int k = 0; k < TAIL_DEPTH; k++) begin
      send_value(v, k == 0);
      v = v + $urandom_range(1, 1 << 21);
    end

    // With the table full, mix dropped appends and in-table replacements.
    for (int k = 0; k < EXTRA_ITEMS; k++) begin
      if (k % 2 == 0) send_value(32'sh7FFF_FFFF - $urandom_range(0, 7), 1'b0);
      else send_value($urandom, 1'b0);
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d values, checked %0d results; longest length %0d, %0d dropped appends.",
             items_sent, results_checked, longest_seen, full_drops);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int          stall;
    logic        held;
    lis_result_t want;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_checked % 64 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      stall = sink_burst ? 0 : $urandom_range(0, 8);
      // One long hold-off lets the block fill up and push back on its input.
      if (!held && results_checked == HOLD_AT) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      results_checked++;
      if (out_ch.full_res) full_drops++;
      if (int'(out_ch.lis_length) > longest_seen) longest_seen = int'(out_ch.lis_length);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, lis_length", int'(out_ch.lis_length), -1);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.lis_length !== want.len)
          report_mismatch("lis_length", int'(out_ch.lis_length), int'(want.len));
        if (out_ch.full_res !== want.full)
          report_mismatch("full_res", int'(out_ch.full_res), int'(want.full));
      end
    end
  end

  // Ends the run if neither channel moves a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("No transfer for %0d cycles, %0d results outstanding.",
                 idle_cycles, pending_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- longest_increasing_subsequence_length.f -----
+incdir+design
design/lis_pkg.sv
design/lis_in_if.sv
design/lis_out_if.sv
design/longest_increasing_subsequence_length.sv
verif/longest_increasing_subsequence_length_tb.sv
